FILE: sv/dsis_pkg.sv
// Shared types, constants and codes for the DHCP server identifier snooper.
package dsis_pkg;

	// Sizing of the server table and the longest packet that is parsed.
	localparam int TABLE_DEPTH      = 32;
	localparam int MAX_PACKET_BYTES = 1024;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

	// Depth of the summary queue between the parser and the table engine.
	localparam int SUMQ_DEPTH = 2;
	localparam int SUMQ_AW    = $clog2(SUMQ_DEPTH);
	localparam int SUMQ_CW    = $clog2(SUMQ_DEPTH + 1);

	// Packet layout and option codes.
	localparam int COOKIE_POS    = 236;
	localparam int OPTIONS_POS   = 240;
	localparam logic [7:0] COOKIE_B0 = 8'd99;
	localparam logic [7:0] COOKIE_B1 = 8'd130;
	localparam logic [7:0] COOKIE_B2 = 8'd83;
	localparam logic [7:0] COOKIE_B3 = 8'd99;
	localparam logic [7:0] OPT_PAD       = 8'd0;
	localparam logic [7:0] OPT_END       = 8'hff;
	localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
	localparam logic [7:0] OPT_SERVER_ID = 8'd54;
	localparam logic [7:0] SERVER_ID_LEN = 8'd4;
	localparam logic [7:0] MSG_OFFER     = 8'd2;
	localparam logic [7:0] MSG_ACK       = 8'd5;

	// Result status codes.
	localparam logic [2:0] ST_NOT_DHCP   = 3'd0;
	localparam logic [2:0] ST_NO_ID      = 3'd1;
	localparam logic [2:0] ST_KNOWN      = 3'd2;
	localparam logic [2:0] ST_ADDED      = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	// Option walk phases.
	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	// Packet classes handed from the parser to the table engine.
	typedef enum logic [1:0] {
		K_NOT_DHCP,
		K_NO_ID,
		K_LOOKUP
	} kind_t;

	// Table engine states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CMP,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] server_addr;
		logic [4:0]  entry_index;
	} result_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] server_addr;
	} summary_t;

	// Queue handshake between two internal parts.
	typedef struct packed {
		logic full;
		logic empty;
	} sumq_status_t;

endpackage

FILE: sv/dsis_front.sv
// Byte parser: cookie check, option walk, and one summary per packet.
module dsis_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  dsis_pkg::byte_req_t   byte_req,
	input  logic                  sumq_full,
	output logic                  sum_push,
	output dsis_pkg::summary_t    sum_data
);

	logic [dsis_pkg::POS_W-1:0] pos_q, pos_n;
	dsis_pkg::phase_t            phase_q, phase_n;
	logic                        bad_q, bad_n;
	logic [7:0]                  opt_q, opt_n;
	logic [7:0]                  left_q, left_n;
	logic                        offer_q, offer_n;
	logic [31:0]                 shift_q, shift_n;
	logic                        complete_q, complete_n;
	logic                        pend_q, pend_n;
	logic                        first_q, first_n;
	logic                        capt_q, capt_n;
	logic                        take;
	logic [7:0]                  b;

	assign full = sumq_full;
	assign take = push && !sumq_full;
	assign b    = byte_req.packet_byte;

	// Next parse state for the byte on the input.
	always_comb begin
		pos_n      = pos_q;
		phase_n    = phase_q;
		bad_n      = bad_q;
		opt_n      = opt_q;
		left_n     = left_q;
		offer_n    = offer_q;
		shift_n    = shift_q;
		complete_n = complete_q;
		pend_n     = pend_q;
		first_n    = first_q;
		capt_n     = capt_q;
		if (pos_q < dsis_pkg::POS_W'(dsis_pkg::MAX_PACKET_BYTES)) begin
			if (pos_q == dsis_pkg::POS_W'(dsis_pkg::COOKIE_POS) && b != dsis_pkg::COOKIE_B0)
				bad_n = 1'b1;
			if (pos_q == dsis_pkg::POS_W'(dsis_pkg::COOKIE_POS + 1) && b != dsis_pkg::COOKIE_B1)
				bad_n = 1'b1;
			if (pos_q == dsis_pkg::POS_W'(dsis_pkg::COOKIE_POS + 2) && b != dsis_pkg::COOKIE_B2)
				bad_n = 1'b1;
			if (pos_q == dsis_pkg::POS_W'(dsis_pkg::COOKIE_POS + 3) && b != dsis_pkg::COOKIE_B3)
				bad_n = 1'b1;
			if (pos_q >= dsis_pkg::POS_W'(dsis_pkg::OPTIONS_POS)) begin
				unique case (phase_q)
					dsis_pkg::PH_CODE: begin
						if (b == dsis_pkg::OPT_END) begin
							phase_n = dsis_pkg::PH_DONE;
						end else if (b != dsis_pkg::OPT_PAD) begin
							opt_n   = b;
							phase_n = dsis_pkg::PH_LEN;
						end
					end
					dsis_pkg::PH_LEN: begin
						left_n = b;
						if (b == 8'd0) begin
							phase_n = dsis_pkg::PH_CODE;
						end else begin
							capt_n  = (opt_q == dsis_pkg::OPT_SERVER_ID) &&
								(b == dsis_pkg::SERVER_ID_LEN);
							first_n = 1'b1;
							pend_n  = 1'b0;
							shift_n = 32'd0;
							phase_n = dsis_pkg::PH_DATA;
						end
					end
					dsis_pkg::PH_DATA: begin
						if (opt_q == dsis_pkg::OPT_MSG_TYPE && first_q)
							pend_n = (b == dsis_pkg::MSG_OFFER) || (b == dsis_pkg::MSG_ACK);
						first_n = 1'b0;
						if (capt_q)
							shift_n = {shift_q[23:0], b};
						left_n = left_q - 8'd1;
						if (left_n == 8'd0) begin
							if (opt_q == dsis_pkg::OPT_MSG_TYPE && pend_n)
								offer_n = 1'b1;
							if (capt_q) begin
								complete_n = 1'b1;
								phase_n    = dsis_pkg::PH_DONE;
							end else begin
								phase_n = dsis_pkg::PH_CODE;
							end
							capt_n = 1'b0;
						end
					end
					dsis_pkg::PH_DONE: begin
						phase_n = dsis_pkg::PH_DONE;
					end
					default: begin
						phase_n = dsis_pkg::PH_DONE;
					end
				endcase
			end
			pos_n = pos_q + dsis_pkg::POS_W'(1);
		end
	end

	// Classify the packet when its last byte arrives.
	always_comb begin
		sum_push             = take && byte_req.last_byte;
		sum_data.server_addr = shift_n;
		if (pos_n < dsis_pkg::POS_W'(dsis_pkg::OPTIONS_POS) || bad_n)
			sum_data.kind = dsis_pkg::K_NOT_DHCP;
		else if (complete_n && offer_n)
			sum_data.kind = dsis_pkg::K_LOOKUP;
		else
			sum_data.kind = dsis_pkg::K_NO_ID;
	end

	// Parse state registers; per-packet state clears after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= dsis_pkg::PH_CODE;
			bad_q      <= 1'b0;
			opt_q      <= 8'd0;
			left_q     <= 8'd0;
			offer_q    <= 1'b0;
			shift_q    <= 32'd0;
			complete_q <= 1'b0;
			pend_q     <= 1'b0;
			first_q    <= 1'b0;
			capt_q     <= 1'b0;
		end else if (take) begin
			if (byte_req.last_byte) begin
				pos_q      <= '0;
				phase_q    <= dsis_pkg::PH_CODE;
				bad_q      <= 1'b0;
				opt_q      <= 8'd0;
				left_q     <= 8'd0;
				offer_q    <= 1'b0;
				shift_q    <= 32'd0;
				complete_q <= 1'b0;
				pend_q     <= 1'b0;
				first_q    <= 1'b0;
				capt_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				phase_q    <= phase_n;
				bad_q      <= bad_n;
				opt_q      <= opt_n;
				left_q     <= left_n;
				offer_q    <= offer_n;
				shift_q    <= shift_n;
				complete_q <= complete_n;
				pend_q     <= pend_n;
				first_q    <= first_n;
				capt_q     <= capt_n;
			end
		end
	end

endmodule

FILE: sv/dsis_sumq.sv
// Short queue of packet summaries between the parser and the table engine.
module dsis_sumq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  dsis_pkg::summary_t      wr_data,
	input  logic                    rd_en,
	output dsis_pkg::summary_t      rd_data,
	output dsis_pkg::sumq_status_t  stat
);

	dsis_pkg::summary_t           slots_q [dsis_pkg::SUMQ_DEPTH];
	logic [dsis_pkg::SUMQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [dsis_pkg::SUMQ_CW-1:0] count_q;
	logic                         do_wr, do_rd;

	assign stat.full  = (count_q == dsis_pkg::SUMQ_CW'(dsis_pkg::SUMQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = slots_q[rd_ptr_q];

	// Storage for the queued summaries.
	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wr_ptr_q] <= wr_data;
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == dsis_pkg::SUMQ_AW'(dsis_pkg::SUMQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + dsis_pkg::SUMQ_AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == dsis_pkg::SUMQ_AW'(dsis_pkg::SUMQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + dsis_pkg::SUMQ_AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + dsis_pkg::SUMQ_CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - dsis_pkg::SUMQ_CW'(1);
		end
	end

endmodule

FILE: sv/dsis_back.sv
// Table engine: searches the server table, adds new servers, holds the result.
module dsis_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsis_pkg::sumq_status_t  sumq_stat,
	input  dsis_pkg::summary_t      sum_data,
	output logic                    sum_pop,
	output logic                    empty,
	input  logic                    pop,
	output dsis_pkg::result_t       result
);

	logic [31:0]                 table_mem [dsis_pkg::TABLE_DEPTH];
	logic [31:0]                 rd_data_q;
	dsis_pkg::back_state_t       state_q, state_n;
	dsis_pkg::kind_t             kind_q;
	logic [31:0]                 ip_q;
	logic [dsis_pkg::IDX_W-1:0]  scan_q;
	logic                        found_q;
	logic [dsis_pkg::CNT_W-1:0]  count_q;
	logic                        out_valid_q;
	dsis_pkg::result_t           out_q;
	logic                        out_free;
	logic                        out_load;
	logic                        table_wr;
	logic                        last_scan;
	logic                        match;
	logic                        has_room;
	dsis_pkg::result_t           res_n;
	logic [31:0]                 slot_ext;

	assign out_free  = !out_valid_q || pop;
	assign has_room  = count_q < dsis_pkg::CNT_W'(dsis_pkg::TABLE_DEPTH);
	assign match     = (rd_data_q == ip_q);
	assign last_scan = (dsis_pkg::CNT_W'(scan_q) + dsis_pkg::CNT_W'(1)) == count_q;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dsis_pkg::BK_IDLE: begin
				if (!sumq_stat.empty) begin
					if (sum_data.kind == dsis_pkg::K_LOOKUP && count_q != '0)
						state_n = dsis_pkg::BK_READ;
					else
						state_n = dsis_pkg::BK_FINISH;
				end
			end
			dsis_pkg::BK_READ: begin
				state_n = dsis_pkg::BK_CMP;
			end
			dsis_pkg::BK_CMP: begin
				if (match || last_scan)
					state_n = dsis_pkg::BK_FINISH;
				else
					state_n = dsis_pkg::BK_READ;
			end
			dsis_pkg::BK_FINISH: begin
				if (out_free)
					state_n = dsis_pkg::BK_IDLE;
			end
			default: begin
				state_n = dsis_pkg::BK_IDLE;
			end
		endcase
	end

	// Control outputs of the engine.
	always_comb begin
		sum_pop  = (state_q == dsis_pkg::BK_IDLE) && !sumq_stat.empty;
		out_load = (state_q == dsis_pkg::BK_FINISH) && out_free;
		table_wr = out_load && (kind_q == dsis_pkg::K_LOOKUP) && !found_q && has_room;
	end

	// Result of the finished request.
	always_comb begin
		res_n.status      = dsis_pkg::ST_NO_ID;
		res_n.server_addr = 32'd0;
		slot_ext          = 32'd0;
		unique case (kind_q)
			dsis_pkg::K_NOT_DHCP: begin
				res_n.status = dsis_pkg::ST_NOT_DHCP;
			end
			dsis_pkg::K_LOOKUP: begin
				res_n.server_addr = ip_q;
				if (found_q) begin
					res_n.status = dsis_pkg::ST_KNOWN;
					slot_ext     = 32'(scan_q);
				end else if (has_room) begin
					res_n.status = dsis_pkg::ST_ADDED;
					slot_ext     = 32'(count_q);
				end else begin
					res_n.status = dsis_pkg::ST_TABLE_FULL;
				end
			end
			default: begin
				res_n.status = dsis_pkg::ST_NO_ID;
			end
		endcase
		res_n.entry_index = slot_ext[4:0];
	end

	// Server table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (table_wr)
			table_mem[count_q[dsis_pkg::IDX_W-1:0]] <= ip_q;
		if (state_q == dsis_pkg::BK_READ)
			rd_data_q <= table_mem[scan_q];
	end

	// Request payload, scan index and output register contents.
	always_ff @(posedge clk) begin
		if (sum_pop) begin
			kind_q <= sum_data.kind;
			ip_q   <= sum_data.server_addr;
			scan_q <= '0;
		end else if (state_q == dsis_pkg::BK_CMP && !match && !last_scan) begin
			scan_q <= scan_q + dsis_pkg::IDX_W'(1);
		end
		if (out_load)
			out_q <= res_n;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsis_pkg::BK_IDLE;
			found_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (sum_pop)
				found_q <= 1'b0;
			else if (state_q == dsis_pkg::BK_CMP && match)
				found_q <= 1'b1;
			if (table_wr)
				count_q <= count_q + dsis_pkg::CNT_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	// The table never holds more servers than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dsis_pkg::CNT_W'(dsis_pkg::TABLE_DEPTH))
		else $error("server table count exceeds its depth");

	// A comparison only ever looks at a filled slot.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsis_pkg::BK_CMP |-> dsis_pkg::CNT_W'(scan_q) < count_q)
		else $error("table scan reached an unfilled slot");

	// Adding a server grows the table by exactly one.
	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		table_wr |=> count_q == $past(count_q) + dsis_pkg::CNT_W'(1))
		else $error("table add did not advance the count");

	// Not-DHCP and no-id results carry a zero address.
	a_zero_ip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == dsis_pkg::ST_NOT_DHCP ||
			out_q.status == dsis_pkg::ST_NO_ID)) |-> out_q.server_addr == 32'd0)
		else $error("server address set on a result without a server");

endmodule

FILE: sv/dhcp_server_id_snooper.sv
// The summary of a packet is queued when its last byte is accepted; an idle table engine
// pops it, compares up to TABLE_DEPTH slots in turn and registers the result.
// Throughput: one byte per cycle; the table search runs during the next packet's bytes,
// and push waits only when both summary queue slots are taken.
// Reset clears parse and queue state, table count and empty flag; table stays unknown.
// Top level of the DHCP server identifier snooper.
module dhcp_server_id_snooper (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  dsis_pkg::byte_req_t  byte_req,
	output logic                 empty,
	input  logic                 pop,
	output dsis_pkg::result_t    result
);

	dsis_pkg::sumq_status_t sumq_stat;
	dsis_pkg::summary_t     sum_wr;
	dsis_pkg::summary_t     sum_rd;
	logic                   sum_push;
	logic                   sum_pop;

	dsis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.byte_req  (byte_req),
		.sumq_full (sumq_stat.full),
		.sum_push  (sum_push),
		.sum_data  (sum_wr)
	);

	dsis_sumq u_sumq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sum_push),
		.wr_data (sum_wr),
		.rd_en   (sum_pop),
		.rd_data (sum_rd),
		.stat    (sumq_stat)
	);

	dsis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sumq_stat (sumq_stat),
		.sum_data  (sum_rd),
		.sum_pop   (sum_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the DHCP server identifier snooper, with a byte-level predictor.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	dsis_pkg::byte_req_t byte_req = '0;
	logic                empty;
	logic                pop = 1'b0;
	dsis_pkg::result_t   result;

	dhcp_server_id_snooper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_req (byte_req),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Per-frame snooping state of the predictor, at its reset values.
	int               byte_pos = 0;
	dsis_pkg::phase_t walk_phase = dsis_pkg::PH_CODE;
	bit               cookie_bad = 1'b0;
	logic [7:0]       opt_code = '0;
	logic [7:0]       opt_left = '0;
	bit               offer_seen = 1'b0;
	logic [31:0]      id_shift = '0;
	bit               id_done = 1'b0;
	bit               msg_offer = 1'b0;
	bit               first_value = 1'b0;
	bit               grab_id = 1'b0;

	// Server table as the predictor sees it; it persists across frames.
	logic [31:0] known_servers [dsis_pkg::TABLE_DEPTH];
	int          known_count = 0;

	dsis_pkg::result_t expected_verdicts [$];
	logic [7:0]        frame [$];

	int error_count = 0;
	int cycle_count = 0;
	int input_stall_cycles = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int verdicts_checked = 0;
	int status_hits [5] = '{default: 0};

	// Idling controls shared by the sender, the receiver and the tests.
	int tx_gap_max = 0;
	int rx_gap_max = 0;
	bit vary_idling = 1'b1;
	int hold_left = 0;

	function automatic void flag_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at cycle %0d: %s", cycle_count, what);
	endfunction

	// Walks one accepted byte through the frame state and predicts the verdict on the last one.
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		dsis_pkg::result_t verdict;
		int                i;
		bit                hit;
		verdict = '0;
		hit = 1'b0;
		if (byte_pos < dsis_pkg::MAX_PACKET_BYTES) begin
			case (byte_pos)
				dsis_pkg::COOKIE_POS:
					if (b != dsis_pkg::COOKIE_B0) cookie_bad = 1'b1;
				dsis_pkg::COOKIE_POS + 1:
					if (b != dsis_pkg::COOKIE_B1) cookie_bad = 1'b1;
				dsis_pkg::COOKIE_POS + 2:
					if (b != dsis_pkg::COOKIE_B2) cookie_bad = 1'b1;
				dsis_pkg::COOKIE_POS + 3:
					if (b != dsis_pkg::COOKIE_B3) cookie_bad = 1'b1;
				default: ;
			endcase
			if (byte_pos >= dsis_pkg::OPTIONS_POS) begin
				case (walk_phase)
					dsis_pkg::PH_CODE: begin
						if (b == dsis_pkg::OPT_END) begin
							walk_phase = dsis_pkg::PH_DONE;
						end else if (b != dsis_pkg::OPT_PAD) begin
							opt_code = b;
							walk_phase = dsis_pkg::PH_LEN;
						end
					end
					dsis_pkg::PH_LEN: begin
						opt_left = b;
						if (b == 8'd0) begin
							walk_phase = dsis_pkg::PH_CODE;
						end else begin
							grab_id = (opt_code == dsis_pkg::OPT_SERVER_ID) &&
								(b == dsis_pkg::SERVER_ID_LEN);
							first_value = 1'b1;
							msg_offer = 1'b0;
							id_shift = '0;
							walk_phase = dsis_pkg::PH_DATA;
						end
					end
					dsis_pkg::PH_DATA: begin
						// Only the first value byte of the message type option counts.
						if (opt_code == dsis_pkg::OPT_MSG_TYPE && first_value)
							msg_offer = (b == dsis_pkg::MSG_OFFER) || (b == dsis_pkg::MSG_ACK);
						first_value = 1'b0;
						if (grab_id)
							id_shift = {id_shift[23:0], b};
						opt_left = opt_left - 8'd1;
						if (opt_left == 8'd0) begin
							if (opt_code == dsis_pkg::OPT_MSG_TYPE && msg_offer)
								offer_seen = 1'b1;
							if (grab_id) begin
								id_done = 1'b1;
								walk_phase = dsis_pkg::PH_DONE;
							end else begin
								walk_phase = dsis_pkg::PH_CODE;
							end
							grab_id = 1'b0;
						end
					end
					default: ;
				endcase
			end
			byte_pos++;
		end
		if (!last)
			return;

		// End of frame: classify, then look up or insert the server.
		verdict.status = dsis_pkg::ST_NO_ID;
		if (byte_pos < dsis_pkg::OPTIONS_POS || cookie_bad) begin
			verdict.status = dsis_pkg::ST_NOT_DHCP;
		end else if (id_done && offer_seen) begin
			verdict.server_addr = id_shift;
			for (i = 0; i < known_count; i++) begin
				if (!hit && known_servers[i] == id_shift) begin
					hit = 1'b1;
					verdict.entry_index = 5'(i);
				end
			end
			if (hit) begin
				verdict.status = dsis_pkg::ST_KNOWN;
			end else if (known_count < dsis_pkg::TABLE_DEPTH) begin
				known_servers[known_count] = id_shift;
				verdict.entry_index = 5'(known_count);
				known_count++;
				verdict.status = dsis_pkg::ST_ADDED;
			end else begin
				verdict.status = dsis_pkg::ST_TABLE_FULL;
			end
		end
		expected_verdicts.push_back(verdict);

		byte_pos = 0;
		walk_phase = dsis_pkg::PH_CODE;
		cookie_bad = 1'b0;
		opt_code = '0;
		opt_left = '0;
		offer_seen = 1'b0;
		id_shift = '0;
		id_done = 1'b0;
		msg_offer = 1'b0;
		first_value = 1'b0;
		grab_id = 1'b0;
	endfunction

	// Frame building blocks.
	function automatic void add_noise(input int n);
		int i;
		for (i = 0; i < n; i++)
			frame.push_back(8'($urandom));
	endfunction

	// Random BOOTP header and cookie; spoil selects a cookie byte to corrupt.
	function automatic void start_frame(input int spoil = -1);
		frame.delete();
		add_noise(dsis_pkg::COOKIE_POS);
		frame = {frame, dsis_pkg::COOKIE_B0, dsis_pkg::COOKIE_B1, dsis_pkg::COOKIE_B2,
			dsis_pkg::COOKIE_B3};
		if (spoil >= 0)
			frame[dsis_pkg::COOKIE_POS + spoil] ^= 8'($urandom_range(255, 1));
	endfunction

	function automatic void add_option(input logic [7:0] code, input logic [7:0] len);
		frame = {frame, code, len};
		add_noise(int'(len));
	endfunction

	function automatic void add_msg_type(input logic [7:0] kind);
		frame = {frame, dsis_pkg::OPT_MSG_TYPE, 8'd1, kind};
	endfunction

	function automatic void add_server_id(input logic [31:0] ip);
		frame = {frame, dsis_pkg::OPT_SERVER_ID, dsis_pkg::SERVER_ID_LEN,
			ip[31:24], ip[23:16], ip[15:8], ip[7:0]};
	endfunction

	// Offers one byte and waits until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		byte_req <= '{packet_byte: b, last_byte: last};
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
		predict_byte(b, last);
	endtask

	task automatic send_frame();
		int i;
		if (vary_idling) begin
			tx_gap_max = ($urandom_range(3, 0) == 0) ? 11 : 0;
			rx_gap_max = ($urandom_range(3, 0) == 0) ? 11 : 0;
		end
		for (i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1);
		frames_sent++;
	endtask

	// Sender goes quiet until every predicted verdict has been popped.
	task automatic wait_for_verdicts();
		push <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Hand-picked frames for each rule of the option walk.
	task automatic test_directed_frames();
		int k;
		// Single-byte frames at both byte extremes are far too short.
		frame = {8'h00};
		send_frame();
		frame = {8'hff};
		send_frame();
		// One byte short of a full cookie, then the smallest real DHCP frame.
		start_frame();
		void'(frame.pop_back());
		send_frame();
		start_frame();
		send_frame();
		// A corrupted cookie byte at each position hides a valid offer.
		for (k = 0; k < 4; k++) begin
			start_frame(k);
			add_msg_type(dsis_pkg::MSG_OFFER);
			add_server_id(32'hc0a80001);
			send_frame();
		end
		// An offer adds the server; a later ACK finds it again.
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(32'hc0a80001);
		frame.push_back(dsis_pkg::OPT_END);
		send_frame();
		start_frame();
		add_msg_type(dsis_pkg::MSG_ACK);
		add_server_id(32'hc0a80001);
		send_frame();
		// Extreme addresses.
		start_frame();
		add_msg_type(dsis_pkg::MSG_ACK);
		add_server_id(32'h00000000);
		send_frame();
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(32'hffffffff);
		send_frame();
		// Other message type, identifier ahead of the offer, empty message type.
		start_frame();
		add_msg_type(8'd1);
		add_server_id(32'h0a000001);
		send_frame();
		start_frame();
		add_server_id(32'h0a000002);
		add_msg_type(dsis_pkg::MSG_OFFER);
		send_frame();
		start_frame();
		add_option(dsis_pkg::OPT_MSG_TYPE, 8'd0);
		add_server_id(32'h0a000003);
		send_frame();
		// Only the first value byte of a long message type option matters.
		start_frame();
		frame = {frame, dsis_pkg::OPT_MSG_TYPE, 8'd3, dsis_pkg::MSG_ACK, 8'd1, 8'd1};
		add_server_id(32'h0a000004);
		send_frame();
		start_frame();
		frame = {frame, dsis_pkg::OPT_MSG_TYPE, 8'd2, 8'd1, dsis_pkg::MSG_OFFER};
		add_server_id(32'h0a000005);
		send_frame();
		// A server id of the wrong length is skipped; the later proper one counts.
		start_frame();
		frame = {frame, dsis_pkg::OPT_SERVER_ID, 8'd3, 8'd10, 8'd0, 8'd0};
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(32'h0a000006);
		send_frame();
		// Pads, then the end option: nothing after it is parsed.
		start_frame();
		frame = {frame, dsis_pkg::OPT_PAD, dsis_pkg::OPT_PAD, dsis_pkg::OPT_PAD,
			dsis_pkg::OPT_END};
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(32'h0a000007);
		send_frame();
		// Server id and message type cut off by the end of the frame.
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		frame = {frame, dsis_pkg::OPT_SERVER_ID, dsis_pkg::SERVER_ID_LEN, 8'd10, 8'd0};
		send_frame();
		start_frame();
		frame = {frame, dsis_pkg::OPT_MSG_TYPE, 8'd1};
		send_frame();
		// The first proper server id wins over a second one.
		start_frame();
		add_msg_type(dsis_pkg::MSG_ACK);
		add_server_id(32'h0a000008);
		add_server_id(32'h0a000009);
		send_frame();
		// Overlong frames: tail ignored, and an id straddling the limit is lost.
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(32'h0a00000a);
		frame.push_back(dsis_pkg::OPT_END);
		add_noise(1100 - frame.size());
		send_frame();
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		while (frame.size() < dsis_pkg::MAX_PACKET_BYTES - 2)
			frame.push_back(dsis_pkg::OPT_PAD);
		add_server_id(32'h0a00000b);
		add_noise(40);
		send_frame();
		wait_for_verdicts();
	endtask

	// Mostly well-formed frames with random options, plus noise and broken frames.
	task automatic test_random_traffic(input int n_frames);
		int          f;
		int          k;
		int          pick;
		int          cut;
		logic [31:0] ip;
		for (f = 0; f < n_frames; f++) begin
			pick = $urandom_range(99, 0);
			if (pick < 10) begin
				frame.delete();
				add_noise($urandom_range(260, 1));
			end else begin
				start_frame((pick < 16) ? $urandom_range(3, 0) : -1);
				for (k = $urandom_range(3, 0); k > 0; k--) begin
					case ($urandom_range(5, 0))
						0: frame.push_back(dsis_pkg::OPT_PAD);
						1: add_option(8'($urandom_range(254, 1)), 8'($urandom_range(6, 0)));
						2: add_option(dsis_pkg::OPT_MSG_TYPE, 8'($urandom_range(3, 0)));
						3: add_option(dsis_pkg::OPT_SERVER_ID, 8'($urandom_range(6, 0)));
						default: add_msg_type(8'($urandom));
					endcase
				end
				if ($urandom_range(9, 0) != 0)
					add_msg_type($urandom_range(1, 0) ? dsis_pkg::MSG_OFFER : dsis_pkg::MSG_ACK);
				for (k = $urandom_range(2, 0); k > 0; k--)
					add_option(8'($urandom_range(254, 1)), 8'($urandom_range(8, 0)));
				// Half the identifiers repeat a server that is already known.
				if (known_count > 0 && $urandom_range(1, 0) == 1)
					ip = known_servers[$urandom_range(known_count - 1, 0)];
				else
					ip = $urandom;
				if ($urandom_range(9, 0) != 0)
					add_server_id(ip);
				if ($urandom_range(7, 0) == 0) begin
					cut = $urandom_range(frame.size() - 1, dsis_pkg::OPTIONS_POS);
					while (frame.size() > cut)
						void'(frame.pop_back());
				end else begin
					if ($urandom_range(1, 0) == 1)
						frame.push_back(dsis_pkg::OPT_END);
					add_noise($urandom_range(20, 0));
					if ($urandom_range(39, 0) == 0)
						add_noise(1100 - frame.size());
				end
			end
			send_frame();
		end
		wait_for_verdicts();
	endtask

	// New servers until the table is full, two refused ones, then hits at both ends.
	task automatic test_table_fill();
		int k;
		while (known_count < dsis_pkg::TABLE_DEPTH) begin
			start_frame();
			add_msg_type(dsis_pkg::MSG_OFFER);
			add_server_id($urandom);
			frame.push_back(dsis_pkg::OPT_END);
			send_frame();
		end
		for (k = 0; k < 2; k++) begin
			start_frame();
			add_msg_type(dsis_pkg::MSG_ACK);
			add_server_id($urandom);
			send_frame();
		end
		start_frame();
		add_msg_type(dsis_pkg::MSG_ACK);
		add_server_id(known_servers[dsis_pkg::TABLE_DEPTH - 1]);
		send_frame();
		start_frame();
		add_msg_type(dsis_pkg::MSG_OFFER);
		add_server_id(known_servers[0]);
		send_frame();
		wait_for_verdicts();
	endtask

	// Long receiver stall during a slow lookup and a burst of tiny frames fills the block.
	task automatic test_backpressure();
		int k;
		vary_idling = 1'b0;
		tx_gap_max = 0;
		rx_gap_max = 0;
		hold_left = 400;
		start_frame();
		add_msg_type(dsis_pkg::MSG_ACK);
		add_server_id(known_servers[known_count - 1]);
		send_frame();
		for (k = 0; k < 16; k++) begin
			frame = {8'($urandom)};
			send_frame();
		end
		wait_for_verdicts();
		vary_idling = 1'b1;
	endtask

	// Cycle count, input stall count and the run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (push && full)
			input_stall_cycles++;
	end

	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Pops verdicts at a random pace and compares each with the oldest prediction.
	initial begin : verdict_checker
		int                pop_wait;
		dsis_pkg::result_t want;
		pop_wait = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0) begin
					flag_error($sformatf("result with nothing expected: status %0d ip %h index %0d",
						result.status, result.server_addr, result.entry_index));
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_checked++;
					status_hits[want.status]++;
					if (result.status !== want.status)
						flag_error($sformatf("status: expected %0d, got %0d",
							want.status, result.status));
					if (result.server_addr !== want.server_addr)
						flag_error($sformatf("server_addr: expected %h, got %h",
							want.server_addr, result.server_addr));
					if (result.entry_index !== want.entry_index)
						flag_error($sformatf("entry_index: expected %0d, got %0d",
							want.entry_index, result.entry_index));
				end
				pop_wait = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Reset once, run the tests in turn, then report.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_traffic(60);
		test_table_fill();
		test_backpressure();
		test_random_traffic(25);

		wait_for_verdicts();
		repeat (4 * dsis_pkg::TABLE_DEPTH + 16) @(posedge clk);

		$display("Checked %0d verdicts from %0d frames, %0d bytes: not DHCP %0d, no id %0d,",
			verdicts_checked, frames_sent, bytes_sent, status_hits[dsis_pkg::ST_NOT_DHCP],
			status_hits[dsis_pkg::ST_NO_ID]);
		$display("known %0d, added %0d, table full %0d; input stalled %0d of %0d cycles.",
			status_hits[dsis_pkg::ST_KNOWN], status_hits[dsis_pkg::ST_ADDED],
			status_hits[dsis_pkg::ST_TABLE_FULL], input_stall_cycles, cycle_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
